/* sv/ftia_pkg.sv */
// Shared types and constants for the flow table with idle aging.
`timescale 1ns / 1ps
`default_nettype none

package ftia_pkg;

    localparam int SLOT_W       = 6;
    localparam int FLOW_ENTRIES = 1 << SLOT_W;
    localparam int KEY_W        = 48;
    localparam int IDLE_W       = 24;
    localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 3;

    localparam int APB_W        = 32;
    localparam int PADDR_W      = 3;
    localparam int REG_IDX_W    = 1;

    localparam logic [REG_IDX_W-1:0] REG_REAP_LIMIT = 1'b0;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_CLIENT   = 2'd0,
        REQ_UPSTREAM = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_CREATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DIAL_FAIL = 3'd3,
        ST_REFRESHED = 3'd4,
        ST_NOT_LIVE  = 3'd5,
        ST_TICK      = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // result of the shared compare/age unit for one table entry
    typedef struct packed {
        logic              key_eq;
        logic [IDLE_W-1:0] idle_next;
        logic              reap;
    } t_unit_res;

endpackage

`default_nettype wire

/* sv/flow_table_idle_aging_core.sv */
// Flow table with idle aging: sequencer, entry memories and config register.
//
// Input channel (i_valid/o_ready) takes one request: a client datagram
// (key lookup, else allocate lowest free slot), an upstream datagram on a
// slot (refresh its idle counter) or a millisecond tick (age and reap).
// Output channel (o_valid/i_ready) returns exactly one result per request.
// Client datagrams and ticks walk all 64 entries through one shared
// compare/age unit, one entry per cycle off the key and idle memories:
// the request passes through S_SCAN and S_DRAIN to S_APPLY, and the result
// is held in S_OUT. Upstream and ignored requests go straight to S_APPLY.
// One request is in flight at a time; o_ready is low from acceptance until
// the result has been taken. If the receiver stalls, the result is held in
// the output register and no new request is taken. Reset clears all live
// bits, the live count and the reap limit; key and idle memories are not
// cleared (only the contents of live entries are ever used). reap_limit_ms
// sits at APB address 0; the user must write it only when idle, and the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module flow_table_idle_aging_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ftia_pkg::REQ_W-1:0]      i_req_type,
    input  logic [ftia_pkg::KEY_W-1:0]      i_client_key,
    input  logic [ftia_pkg::SLOT_W-1:0]     i_flow_slot,
    input  logic                            i_dial_ok,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ftia_pkg::STATUS_W-1:0]   o_status,
    output logic [ftia_pkg::SLOT_W-1:0]     o_slot_out,
    output logic                            o_first_datagram,
    output logic [ftia_pkg::CNT_W-1:0]      o_reaped_count,
    output logic [ftia_pkg::CNT_W-1:0]      o_live_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ftia_pkg::PADDR_W-1:0]    paddr,
    input  logic [ftia_pkg::APB_W-1:0]      pwdata,
    output logic [ftia_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);
    import ftia_pkg::*;

    t_state                 r_state, n_state;
    t_req                   r_req;
    logic [KEY_W-1:0]       r_key;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_dial;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_cmp_vld;
    logic [SLOT_W-1:0]      r_cmp_idx;
    logic                   r_found;
    logic [SLOT_W-1:0]      r_hit_slot;
    logic                   r_have_free;
    logic [SLOT_W-1:0]      r_free_slot;
    logic [CNT_W-1:0]       r_reaped;
    logic [FLOW_ENTRIES-1:0] r_live;
    logic [CNT_W-1:0]       r_live_cnt;
    logic [IDLE_W-1:0]      r_limit;

    logic [KEY_W-1:0]       r_key_mem  [FLOW_ENTRIES];
    logic [IDLE_W-1:0]      r_idle_mem [FLOW_ENTRIES];
    logic [KEY_W-1:0]       r_key_rd;
    logic [IDLE_W-1:0]      r_idle_rd;

    t_status                r_o_status;
    logic [SLOT_W-1:0]      r_o_slot;
    logic                   r_o_first;
    logic [CNT_W-1:0]       r_o_reaped;
    logic [CNT_W-1:0]       r_o_live;

    t_unit_res              unit_res;
    logic                   in_accept;
    logic                   in_apply;
    logic                   cmp_live;
    logic                   do_hit;
    logic                   do_create;
    logic                   do_refresh;
    logic                   tick_write;
    logic                   tick_reap;
    logic                   key_we;
    logic                   idle_we;
    logic [SLOT_W-1:0]      idle_waddr;
    logic [IDLE_W-1:0]      idle_wdata;
    logic                   cfg_we;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite &&
                    (paddr[PADDR_W-1:2] == REG_REAP_LIMIT);
    assign prdata = (paddr[PADDR_W-1:2] == REG_REAP_LIMIT) ?
                    {(APB_W-IDLE_W)'(0), r_limit} : '0;

    // ---------------- handshake ----------------
    assign in_accept = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign in_apply  = (r_state == S_APPLY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (t_req'(i_req_type) == REQ_CLIENT || t_req'(i_req_type) == REQ_TICK)
                        n_state = S_SCAN;
                    else
                        n_state = S_APPLY;
                end
            end
            S_SCAN: begin
                if (r_idx == SLOT_W'(FLOW_ENTRIES - 1))
                    n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT: begin
                if (i_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- shared unit ----------------
    ftia_unit u_unit (
        .i_key_rd  (r_key_rd),
        .i_key_req (r_key),
        .i_idle    (r_idle_rd),
        .i_limit   (r_limit),
        .o_res     (unit_res)
    );

    assign cmp_live   = r_live[r_cmp_idx];
    assign tick_write = r_cmp_vld && (r_req == REQ_TICK) && cmp_live;
    assign tick_reap  = tick_write && unit_res.reap;

    assign do_hit     = (r_req == REQ_CLIENT) && r_found;
    assign do_create  = (r_req == REQ_CLIENT) && !r_found && r_have_free && r_dial;
    assign do_refresh = (r_req == REQ_UPSTREAM) && r_live[r_slot];

    assign key_we     = in_apply && do_create;
    assign idle_we    = tick_write || (in_apply && (do_hit || do_create || do_refresh));

    always_comb begin
        if (tick_write)
            idle_waddr = r_cmp_idx;
        else if (do_hit)
            idle_waddr = r_hit_slot;
        else if (do_create)
            idle_waddr = r_free_slot;
        else
            idle_waddr = r_slot;
        idle_wdata = tick_write ? unit_res.idle_next : '0;
    end

    // ---------------- entry memories ----------------
    always_ff @(posedge i_clk) begin
        if (key_we)
            r_key_mem[r_free_slot] <= r_key;
        if (idle_we)
            r_idle_mem[idle_waddr] <= idle_wdata;
        if (r_state == S_SCAN) begin
            r_key_rd  <= r_key_mem[r_idx];
            r_idle_rd <= r_idle_mem[r_idx];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_live      <= '0;
            r_live_cnt  <= '0;
            r_limit     <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_reaped    <= '0;
            r_idx       <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);

            if (cfg_we)
                r_limit <= pwdata[IDLE_W-1:0];

            if (in_accept) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_have_free <= 1'b0;
                r_reaped    <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + SLOT_W'(1);
            end

            // client walk: lowest free slot and lowest live match
            if (r_cmp_vld && r_req == REQ_CLIENT) begin
                if (!cmp_live) begin
                    if (!r_have_free)
                        r_have_free <= 1'b1;
                end else if (!r_found && unit_res.key_eq) begin
                    r_found <= 1'b1;
                end
            end

            if (tick_reap) begin
                r_live[r_cmp_idx] <= 1'b0;
                r_live_cnt        <= r_live_cnt - CNT_W'(1);
                r_reaped          <= r_reaped + CNT_W'(1);
            end else if (key_we) begin
                r_live[r_free_slot] <= 1'b1;
                r_live_cnt          <= r_live_cnt + CNT_W'(1);
            end
        end
    end

    // ---------------- request and slot payload ----------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req  <= t_req'(i_req_type);
            r_key  <= i_client_key;
            r_slot <= i_flow_slot;
            r_dial <= i_dial_ok;
        end
        r_cmp_idx <= r_idx;
        if (r_cmp_vld && r_req == REQ_CLIENT) begin
            if (!cmp_live && !r_have_free)
                r_free_slot <= r_cmp_idx;
            if (cmp_live && !r_found && unit_res.key_eq)
                r_hit_slot <= r_cmp_idx;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (in_apply) begin
            r_o_slot   <= '0;
            r_o_first  <= 1'b0;
            r_o_reaped <= '0;
            r_o_live   <= r_live_cnt + CNT_W'(do_create);
            case (r_req)
                REQ_CLIENT: begin
                    if (r_found) begin
                        r_o_status <= ST_HIT;
                        r_o_slot   <= r_hit_slot;
                    end else if (!r_have_free) begin
                        r_o_status <= ST_FULL;
                    end else if (!r_dial) begin
                        r_o_status <= ST_DIAL_FAIL;
                    end else begin
                        r_o_status <= ST_CREATED;
                        r_o_slot   <= r_free_slot;
                        r_o_first  <= 1'b1;
                    end
                end
                REQ_UPSTREAM: begin
                    if (do_refresh) begin
                        r_o_status <= ST_REFRESHED;
                        r_o_slot   <= r_slot;
                    end else begin
                        r_o_status <= ST_NOT_LIVE;
                    end
                end
                default: begin
                    // tick, or an unused code answered as an empty tick
                    r_o_status <= ST_TICK;
                    r_o_reaped <= r_reaped;
                end
            endcase
        end
    end

    assign o_status         = r_o_status;
    assign o_slot_out       = r_o_slot;
    assign o_first_datagram = r_o_first;
    assign o_reaped_count   = r_o_reaped;
    assign o_live_count     = r_o_live;

    // ---------------- assertions ----------------
    a_live_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_live_cnt) == $countones(r_live))
        else $error("live count out of step with live bits");

    a_cmp_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("compare stage active outside a walk");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_write |-> !in_apply)
        else $error("age write collides with apply write");

    a_first_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_first_datagram) |-> (o_status == ST_CREATED))
        else $error("first datagram flagged without a new flow");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_live_count)))
        else $error("stalled result lost");

endmodule

`default_nettype wire

/* sv/ftia_unit.sv */
// Shared compare and age unit: key match, saturating idle increment, reap test.
`timescale 1ns / 1ps
`default_nettype none

module ftia_unit (
    input  logic [ftia_pkg::KEY_W-1:0]  i_key_rd,
    input  logic [ftia_pkg::KEY_W-1:0]  i_key_req,
    input  logic [ftia_pkg::IDLE_W-1:0] i_idle,
    input  logic [ftia_pkg::IDLE_W-1:0] i_limit,
    output ftia_pkg::t_unit_res         o_res
);
    import ftia_pkg::*;

    logic [IDLE_W-1:0] idle_next;

    assign idle_next = (i_idle == IDLE_MAX) ? i_idle : i_idle + IDLE_W'(1);

    always_comb begin
        o_res.key_eq    = (i_key_rd == i_key_req);
        o_res.idle_next = idle_next;
        // zero limit means never reap
        o_res.reap      = (i_limit != '0) && (idle_next >= i_limit);
    end

endmodule

`default_nettype wire
